@@ hdl/polynomial_add_sub_mul_macros.svh @@
// ----------------------------------------------------------------------------
// Polynomial unit assertion macros
// Shared concurrent assertion forms, sampled on clock and off during reset.
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_ADD_SUB_MUL_MACROS_SVH
`define POLYNOMIAL_ADD_SUB_MUL_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PASM_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PASM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/pasm_pkg.sv @@
// ----------------------------------------------------------------------------
// Polynomial unit package
// Codes, sequencer states and the pipeline tag shared by the datapath.
// ----------------------------------------------------------------------------
package pasm_pkg;

   // Input item kinds.
   localparam logic [1:0] MODE_LOAD_FIRST  = 2'd0;
   localparam logic [1:0] MODE_LOAD_SECOND = 2'd1;
   localparam logic [1:0] MODE_RUN         = 2'd2;

   // Operation register codes; the unused code acts as a sum.
   localparam logic [1:0] OP_SUM     = 2'd0;
   localparam logic [1:0] OP_DIFF    = 2'd1;
   localparam logic [1:0] OP_PRODUCT = 2'd2;

   // Register index of the operation register.
   localparam logic REG_OPERATION = 1'b0;

   // Highest number of result terms in one run.
   localparam logic [4:0] OUT_LIMIT = 5'd31;

   localparam int COEFF_W = 16;
   localparam int VALUE_W = 40;
   localparam int POWER_W = 5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GATE,
      ST_ISSUE,
      ST_WAIT
   } state_type;

   // Travels alongside each memory read through the multiply stages.
   typedef struct packed {
      logic valid;
      logic use_a;
      logic use_b;
      logic last;
   } tag_type;

endpackage

@@ hdl/polynomial_add_sub_mul.sv @@
// ----------------------------------------------------------------------------
// Polynomial add / subtract / multiply unit
// Stores two coefficient lists and streams their sum, difference or product.
// ----------------------------------------------------------------------------
// Usage:
//   Input items on req_*: tuser selects load first, load second or run, and
//   tdata carries a signed Q8.8 coefficient. A load gives no result. A run
//   emits one result item per power, lowest first, on rsp_*; tlast marks the
//   highest term and tuser repeats the dropped-load flag. The operation
//   register on the csr_* port picks sum, difference or product; the user
//   must write it only while the block is idle; the block does not enforce it.
//   Each result term is built by a multiply-accumulate that walks both
//   coefficient memories, one read pair per cycle. Beyond issuing its reads,
//   each term passes through the output gate, the memory read with the
//   multiply, and the accumulate stage that hands off into the output register.
//   Input is accepted only between runs; loads are accepted while the last
//   result item still waits. A stalled receiver holds the next term back
//   before its reads start. Reset empties both lists, clears the flag and
//   sets the operation to sum; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "polynomial_add_sub_mul_macros.svh"

module polynomial_add_sub_mul #(
   parameter int MAX_TERMS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [15:0] coefficient
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,
   // req_tuser: [1:0] mode
   input  logic [1:0]  req_tuser,
   // rsp_tdata: [4:0] power, [44:5] value, [47:45] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   output logic        rsp_tlast,
   // rsp_tuser: [0] overflow
   output logic        rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int CW = $clog2(MAX_TERMS + 1);
   localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_TERMS);
   localparam logic [4:0] IDX_MAX = 5'(MAX_TERMS - 1);

   // Coefficient memories.
   logic [15:0] first_mem  [MAX_TERMS];
   logic [15:0] second_mem [MAX_TERMS];
   logic [15:0] rd_a_ff;
   logic [15:0] rd_b_ff;

   pasm_pkg::state_type state_ff, state_in;

   logic [CW-1:0] first_count_ff, first_count_in;
   logic [CW-1:0] second_count_ff, second_count_in;
   logic          dropped_ff, dropped_in;
   logic [1:0]    operation_ff;

   logic [CW-1:0] run_c1_ff, run_c2_ff;
   logic          run_ovf_ff;
   logic [4:0]    len_last_ff;
   logic [4:0]    k_ff, k_in;
   logic [4:0]    i_ff, i_in;

   pasm_pkg::tag_type s1_ff, s2_ff, tag_in;
   logic signed [31:0] prod_ff;
   logic signed [39:0] acc_ff;

   logic        rsp_valid_ff;
   logic [4:0]  rsp_power_ff;
   logic [39:0] rsp_value_ff;
   logic        rsp_last_ff;
   logic        rsp_ovf_ff;

   logic req_fire, run_fire, csr_write;
   logic out_free, term_done, issue;
   logic is_prod, is_diff;
   logic [4:0] i_last, j_idx, addr_a, addr_b;
   logic [CW-1:0] n1, n2;
   logic [6:0] len_raw;
   logic [4:0] len_cap;
   logic signed [15:0] op_a, op_b;
   logic signed [16:0] sum_ab;
   logic signed [31:0] stage2_val;
   logic signed [39:0] acc_sum;

   assign req_fire  = req_tvalid && req_tready;
   assign run_fire  = req_fire && (req_tuser == pasm_pkg::MODE_RUN);
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign term_done = s2_ff.valid && s2_ff.last;
   assign is_prod   = (operation_ff == pasm_pkg::OP_PRODUCT);
   assign is_diff   = (operation_ff == pasm_pkg::OP_DIFF);

   // ---------------------------------------------------------------- config
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == pasm_pkg::REG_OPERATION) ? {30'd0, operation_ff}
                                                                   : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         operation_ff <= pasm_pkg::OP_SUM;
      end else if (csr_write && (csr_paddr[2] == pasm_pkg::REG_OPERATION)) begin
         operation_ff <= csr_pwdata[1:0];
      end
   end

   // ---------------------------------------------------------------- loads
   always_comb begin
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      dropped_in      = dropped_ff;
      if (req_fire) begin
         case (req_tuser)
            pasm_pkg::MODE_LOAD_FIRST: begin
               if (first_count_ff < COUNT_MAX) first_count_in = first_count_ff + 1'b1;
               else dropped_in = 1'b1;
            end
            pasm_pkg::MODE_LOAD_SECOND: begin
               if (second_count_ff < COUNT_MAX) second_count_in = second_count_ff + 1'b1;
               else dropped_in = 1'b1;
            end
            pasm_pkg::MODE_RUN: begin
               first_count_in  = '0;
               second_count_in = '0;
               dropped_in      = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_count_ff  <= '0;
         second_count_ff <= '0;
         dropped_ff      <= 1'b0;
      end else begin
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         dropped_ff      <= dropped_in;
      end
   end

   // Empty lists act as the single coefficient zero.
   assign n1      = (first_count_ff == '0) ? CW'(1) : first_count_ff;
   assign n2      = (second_count_ff == '0) ? CW'(1) : second_count_ff;
   assign len_raw = is_prod ? (7'(n1) + 7'(n2) - 7'd1)
                            : ((n1 > n2) ? 7'(n1) : 7'(n2));
   assign len_cap = (len_raw > 7'(pasm_pkg::OUT_LIMIT)) ? pasm_pkg::OUT_LIMIT : len_raw[4:0];

   always_ff @(posedge clock) begin
      if (run_fire) begin
         run_c1_ff   <= first_count_ff;
         run_c2_ff   <= second_count_ff;
         run_ovf_ff  <= dropped_ff;
         len_last_ff <= len_cap - 5'd1;
      end
   end

   // ---------------------------------------------------------------- sequencer
   assign i_last = !is_prod ? 5'd0 : ((k_ff > IDX_MAX) ? IDX_MAX : k_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pasm_pkg::ST_IDLE:  if (run_fire) state_in = pasm_pkg::ST_GATE;
         pasm_pkg::ST_GATE:  if (out_free) state_in = pasm_pkg::ST_ISSUE;
         pasm_pkg::ST_ISSUE: if (i_ff == i_last) state_in = pasm_pkg::ST_WAIT;
         pasm_pkg::ST_WAIT: begin
            if (term_done) begin
               state_in = (k_ff == len_last_ff) ? pasm_pkg::ST_IDLE : pasm_pkg::ST_GATE;
            end
         end
         default: state_in = pasm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      issue      = 1'b0;
      k_in       = k_ff;
      i_in       = i_ff;
      case (state_ff)
         pasm_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            k_in       = 5'd0;
         end
         pasm_pkg::ST_GATE: begin
            i_in = 5'd0;
         end
         pasm_pkg::ST_ISSUE: begin
            issue = 1'b1;
            i_in  = i_ff + 5'd1;
         end
         pasm_pkg::ST_WAIT: begin
            if (term_done) k_in = k_ff + 5'd1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pasm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      k_ff <= k_in;
      i_ff <= i_in;
   end

   // ---------------------------------------------------------------- memories
   // A product reads a[i] and b[k-i]; a sum or difference reads both at k.
   assign j_idx  = k_ff - i_ff;
   assign addr_a = is_prod ? i_ff : k_ff;
   assign addr_b = is_prod ? j_idx : k_ff;

   always_comb begin
      tag_in.valid = issue;
      tag_in.use_a = (6'(addr_a) < 6'(run_c1_ff));
      tag_in.use_b = (6'(addr_b) < 6'(run_c2_ff));
      tag_in.last  = (i_ff == i_last);
   end

   always_ff @(posedge clock) begin
      if (req_fire && (req_tuser == pasm_pkg::MODE_LOAD_FIRST) &&
          (first_count_ff < COUNT_MAX)) begin
         first_mem[first_count_ff[AW-1:0]] <= req_tdata;
      end
      if (req_fire && (req_tuser == pasm_pkg::MODE_LOAD_SECOND) &&
          (second_count_ff < COUNT_MAX)) begin
         second_mem[second_count_ff[AW-1:0]] <= req_tdata;
      end
      rd_a_ff <= first_mem[addr_a[AW-1:0]];
      rd_b_ff <= second_mem[addr_b[AW-1:0]];
   end

   // ---------------------------------------------------------------- datapath
   assign op_a   = s1_ff.use_a ? $signed(rd_a_ff) : 16'sd0;
   assign op_b   = s1_ff.use_b ? $signed(rd_b_ff) : 16'sd0;
   assign sum_ab = is_diff ? (17'(op_a) - 17'(op_b)) : (17'(op_a) + 17'(op_b));

   always_comb begin
      if (is_prod) stage2_val = 32'(op_a) * 32'(op_b);
      else stage2_val = {{7{sum_ab[16]}}, sum_ab, 8'd0};
   end

   assign acc_sum = acc_ff + 40'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
      end else begin
         s1_ff <= tag_in;
         s2_ff <= s1_ff;
      end
      prod_ff <= stage2_val;
      if (state_ff == pasm_pkg::ST_GATE) acc_ff <= '0;
      else if (s2_ff.valid) acc_ff <= term_done ? 40'sd0 : acc_sum;
   end

   // ---------------------------------------------------------------- output
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (term_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (term_done) begin
         rsp_power_ff <= k_ff;
         rsp_value_ff <= acc_sum;
         rsp_last_ff  <= (k_ff == len_last_ff);
         rsp_ovf_ff   <= run_ovf_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_value_ff, rsp_power_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_ovf_ff;

   // ---------------------------------------------------------------- checks
   `PASM_ASSERT_SAME(a_out_free, term_done, (!rsp_valid_ff || rsp_tready), "term overwrote a pending item")
   `PASM_ASSERT_SAME(a_done_in_wait, term_done, (state_ff == pasm_pkg::ST_WAIT), "term finished outside wait")
   `PASM_ASSERT_SAME(a_index_order, (state_ff == pasm_pkg::ST_ISSUE), (i_ff <= k_ff), "read index passed term power")
   `PASM_ASSERT_NEXT(a_run_clears, run_fire, ((first_count_ff == '0) && (second_count_ff == '0) && !dropped_ff), "run left stored state")

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Polynomial unit testbench
// Loads coefficient lists, issues runs under each operation setting and
// checks every emitted term against a behavioral predictor, with random
// gaps and stalls on both streams and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;

   localparam int MAX_TERMS      = 16;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 30;

   // Codes outside the package list that the block must still tolerate.
   localparam logic [1:0] MODE_IGNORED = 2'd3;
   localparam logic [1:0] OP_ALIAS_SUM = 2'd3;

   typedef struct {
      logic [1:0]  mode;
      logic [15:0] coeff;
   } poly_item_type;

   typedef struct {
      logic [4:0]         power;
      logic signed [39:0] value;
      logic               last;
      logic               overflow;
   } term_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   poly_item_type pending_items[$];
   term_type      expected_terms[$];

   // Predictor state.
   logic signed [15:0] first_poly [MAX_TERMS];
   logic signed [15:0] second_poly[MAX_TERMS];
   int                 first_len = 0;
   int                 second_len = 0;
   logic               load_dropped = 1'b0;
   logic [1:0]         op_shadow = pasm_pkg::OP_SUM;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_trigger = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int mismatches = 0;
   int quiet_cycles = 0;

   polynomial_add_sub_mul #(.MAX_TERMS(MAX_TERMS)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic longint first_at(int idx);
      return (idx < first_len) ? longint'(first_poly[idx]) : 0;
   endfunction

   function automatic longint second_at(int idx);
      return (idx < second_len) ? longint'(second_poly[idx]) : 0;
   endfunction

   // Updates the stored lists for one accepted item and queues the terms
   // that a run produces.
   task automatic apply_poly_item(input logic [1:0] mode, input logic [15:0] coeff);
      int       n_a;
      int       n_b;
      int       n_terms;
      longint   acc;
      term_type t;
      case (mode)
         pasm_pkg::MODE_LOAD_FIRST: begin
            if (first_len < MAX_TERMS) begin
               first_poly[first_len] = coeff;
               first_len++;
            end else begin
               load_dropped = 1'b1;
            end
         end
         pasm_pkg::MODE_LOAD_SECOND: begin
            if (second_len < MAX_TERMS) begin
               second_poly[second_len] = coeff;
               second_len++;
            end else begin
               load_dropped = 1'b1;
            end
         end
         pasm_pkg::MODE_RUN: begin
            // An empty list behaves as the single coefficient zero.
            n_a = (first_len != 0) ? first_len : 1;
            n_b = (second_len != 0) ? second_len : 1;
            if (op_shadow == pasm_pkg::OP_PRODUCT) begin
               n_terms = n_a + n_b - 1;
            end else begin
               n_terms = (n_a > n_b) ? n_a : n_b;
            end
            if (n_terms > pasm_pkg::OUT_LIMIT) begin
               n_terms = pasm_pkg::OUT_LIMIT;
            end
            for (int k = 0; k < n_terms; k++) begin
               acc = 0;
               if (op_shadow == pasm_pkg::OP_PRODUCT) begin
                  for (int i = 0; i <= k && i < MAX_TERMS; i++) begin
                     acc += first_at(i) * second_at(k - i);
                  end
               end else if (op_shadow == pasm_pkg::OP_DIFF) begin
                  acc = (first_at(k) - second_at(k)) * 256;
               end else begin
                  acc = (first_at(k) + second_at(k)) * 256;
               end
               t.power = k[4:0];
               t.value = acc[39:0];
               t.last = (k == n_terms - 1);
               t.overflow = load_dropped;
               expected_terms.push_back(t);
            end
            first_len = 0;
            second_len = 0;
            load_dropped = 1'b0;
         end
         default: begin
         end
      endcase
   endtask

   task automatic note_error(input string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s", msg);
      end
   endtask

   // Item driver.
   always @(posedge clock) begin : item_driver
      poly_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_poly_item(req_tuser, req_tdata);
         end
         if (!req_tvalid || req_tready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= nxt.mode;
               req_tdata <= nxt.coeff;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor.
   always @(posedge clock) begin : term_monitor
      term_type seen;
      term_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            seen.power = rsp_tdata[4:0];
            seen.value = rsp_tdata[44:5];
            seen.last = rsp_tlast;
            seen.overflow = rsp_tuser;
            if (expected_terms.size() == 0) begin
               note_error($sformatf("unexpected term: power %0d value %0d",
                                    seen.power, seen.value));
            end else begin
               want = expected_terms.pop_front();
               if (seen.power !== want.power || seen.value !== want.value ||
                   seen.last !== want.last || seen.overflow !== want.overflow ||
                   rsp_tdata[47:45] !== 3'b000) begin
                  note_error($sformatf({"term mismatch: expected power %0d value %0d ",
                                        "last %0b ovf %0b, got power %0d value %0d ",
                                        "last %0b ovf %0b pad %0h"},
                                       want.power, want.value, want.last, want.overflow,
                                       seen.power, seen.value, seen.last, seen.overflow,
                                       rsp_tdata[47:45]));
               end
            end
         end
      end
   end

   // Receiver ready, including the long hold-off counted in cycles.
   always @(posedge clock) begin : receiver_ready
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_trigger != hold_seen) begin
         hold_seen <= hold_trigger;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("polynomial_add_sub_mul verification failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic add_item(input logic [1:0] mode, input logic [15:0] coeff);
      poly_item_type it;
      it.mode = mode;
      it.coeff = coeff;
      pending_items.push_back(it);
   endtask

   function automatic logic [15:0] rand_coeff();
      case ($urandom_range(7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Loads both lists in a random interleaving, optionally closed by a run.
   task automatic push_sequence(input int n_a, input int n_b, input bit with_run);
      int a_left;
      int b_left;
      a_left = n_a;
      b_left = n_b;
      while (a_left != 0 || b_left != 0) begin
         if (b_left == 0 || (a_left != 0 && $urandom_range(1) == 1)) begin
            add_item(pasm_pkg::MODE_LOAD_FIRST, rand_coeff());
            a_left--;
         end else begin
            add_item(pasm_pkg::MODE_LOAD_SECOND, rand_coeff());
            b_left--;
         end
      end
      if (with_run) begin
         add_item(pasm_pkg::MODE_RUN, rand_coeff());
      end
   endtask

   task automatic run_random(input int budget, input bit full);
      int         done_items;
      int         n_a;
      int         n_b;
      int         pick;
      logic [1:0] mode;
      done_items = 0;
      if (full) begin
         // Both lists filled or overfilled: possible dropped loads and the longest product.
         n_a = $urandom_range(16, 18);
         n_b = $urandom_range(16, 17);
         push_sequence(n_a, n_b, 1'b1);
         done_items += n_a + n_b + 1;
      end
      while (done_items < budget) begin
         pick = $urandom_range(9);
         if (pick == 0) begin
            mode = 2'($urandom_range(3));
            add_item(mode, rand_coeff());
            if (mode != MODE_IGNORED) begin
               done_items++;
            end
         end else begin
            n_a = ($urandom_range(9) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 6);
            n_b = ($urandom_range(9) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 6);
            // Now and then a sequence is left without its run.
            push_sequence(n_a, n_b, pick != 1);
            done_items += n_a + n_b + ((pick != 1) ? 1 : 0);
         end
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (pending_items.size() != 0 || req_tvalid || expected_terms.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_operation(input logic [1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= 3'(4 * pasm_pkg::REG_OPERATION);
      csr_pwdata <= {30'b0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      op_shadow = value;
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Sum at the reset setting: empty lists, an ignored item, unequal lengths.
      add_item(pasm_pkg::MODE_RUN, 16'h0000);
      add_item(MODE_IGNORED, 16'hA5A5);
      add_item(pasm_pkg::MODE_LOAD_FIRST, 16'h7FFF);
      add_item(pasm_pkg::MODE_LOAD_FIRST, 16'h8000);
      add_item(pasm_pkg::MODE_LOAD_SECOND, 16'h8000);
      add_item(pasm_pkg::MODE_RUN, 16'hFFFF);
      wait_idle();

      // Difference with a longer second list, then with an empty second list.
      write_operation(pasm_pkg::OP_DIFF);
      add_item(pasm_pkg::MODE_LOAD_FIRST, 16'h8000);
      add_item(pasm_pkg::MODE_LOAD_SECOND, 16'h7FFF);
      add_item(pasm_pkg::MODE_LOAD_SECOND, 16'hFFFF);
      add_item(pasm_pkg::MODE_LOAD_SECOND, 16'h0001);
      add_item(pasm_pkg::MODE_RUN, 16'h5A5A);
      add_item(pasm_pkg::MODE_LOAD_FIRST, 16'h7FFF);
      add_item(pasm_pkg::MODE_LOAD_FIRST, 16'h0001);
      add_item(pasm_pkg::MODE_RUN, 16'h0000);
      wait_idle();

      // Product at full scale, then with an empty first list.
      write_operation(pasm_pkg::OP_PRODUCT);
      add_item(pasm_pkg::MODE_LOAD_FIRST, 16'h8000);
      add_item(pasm_pkg::MODE_LOAD_FIRST, 16'h8000);
      add_item(pasm_pkg::MODE_LOAD_SECOND, 16'h8000);
      add_item(pasm_pkg::MODE_RUN, 16'h0000);
      add_item(pasm_pkg::MODE_LOAD_SECOND, 16'h7FFF);
      add_item(pasm_pkg::MODE_RUN, 16'h0000);
      run_random(34, 1'b1);
      wait_idle();

      write_operation(OP_ALIAS_SUM);
      set_idling(51, 0);
      run_random(34, 1'b0);
      wait_idle();

      // The receiver holds off while the sender keeps offering items.
      write_operation(pasm_pkg::OP_DIFF);
      set_idling(0, 51);
      hold_trigger++;
      run_random(34, 1'b1);
      wait_idle();

      write_operation(pasm_pkg::OP_PRODUCT);
      set_idling(20, 20);
      run_random(34, 1'b1);
      wait_idle();

      write_operation(pasm_pkg::OP_SUM);
      set_idling(0, 0);
      run_random(34, 1'b0);
      wait_idle();

      repeat (40) @(negedge clock);
      if (mismatches == 0 && expected_terms.size() == 0) begin
         $display("polynomial_add_sub_mul verification clean");
      end else begin
         $display("polynomial_add_sub_mul verification failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/pasm_pkg.sv
hdl/polynomial_add_sub_mul.sv
bench/tb.sv
